// ----- rtl/spr_pkg.sv -----
package spr_pkg;

  // Width of the external step counter that the position extends.
  localparam int unsigned CounterBits = 16;
  localparam logic [15:0] CntMask =
    (CounterBits >= 16) ? 16'hFFFF : 16'((32'd1 << CounterBits) - 32'd1);
  localparam logic [32:0] WrapFull = 33'd1 << CounterBits;
  localparam logic [31:0] WrapAmt  = WrapFull[31:0];

  // Timer values while the pulses are paused.
  localparam logic [7:0]  PausePrescaler = 8'd3;
  localparam logic [15:0] PauseReload    = 16'd65535;
  localparam logic [15:0] PauseCompare   = 16'd0;

  // Largest clipped period magnitude.
  localparam logic [24:0] MagLimit = 25'h0FF_FFFF;

  // The reload divide produces one quotient bit per step.
  localparam int unsigned DivSteps = 16;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Configuration register indexes.
  localparam logic [1:0] CfgPeriodMin  = 2'd0;
  localparam logic [1:0] CfgPeriodMax  = 2'd1;
  localparam logic [1:0] CfgPulseWidth = 2'd2;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    BR_DIR,
    BR_SETTLE,
    BR_PAUSE,
    BR_RUN,
    BR_READ,
    BR_CLEAR,
    BR_NONE
  } branch_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_COMMIT
  } state_e;

  typedef struct packed {
    logic [24:0] period_min;
    logic [24:0] period_max;
    logic [15:0] pulse_width;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/spr_ctrl.sv -----
module spr_ctrl import spr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_PREP;
      end
      S_PREP: begin
        state_d = status_i.need_div ? S_DIV : S_COMMIT;
      end
      S_DIV: begin
        if (status_i.div_last) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      S_COMMIT: begin
        cmd_o.commit = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/spr_dp.sv -----
module spr_dp import spr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic [1:0]         operation_i,
  input  logic signed [24:0] period_i,
  input  logic [15:0]        counter_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               direction_level_o,
  output logic [7:0]         prescaler_o,
  output logic [15:0]        reload_o,
  output logic [15:0]        compare_o,
  output logic signed [31:0] position_o,
  output logic               clear_counter_o
);

  // Latched word.
  op_e         op_q;
  logic [24:0] mag_in_q;
  logic        fwd_q;
  logic [15:0] cnt_q;

  // Divider.
  logic [23:0]        mag_q;
  logic [8:0]         rem_q, rem_d;
  logic [15:0]        quo_q, quo_d;
  logic [DivCntW-1:0] div_cnt_q;

  // Block state.
  logic [31:0] base_q;
  logic [15:0] last_q;
  logic        paused_q, wait_dir_q, wait_settle_q, dir_q;
  logic [7:0]  presc_q;
  logic [15:0] reload_q, compare_q;

  // Result registers.
  logic        out_valid_q;
  logic [31:0] pos_out_q;
  logic        clr_out_q;

  branch_e     br;
  logic [24:0] lo, hi, m_lo, m_hi;
  logic [23:0] m_clip;
  logic [9:0]  trial;
  logic [31:0] base_ext, pos_ext;

  // Which path the latched word takes through the state.
  always_comb begin
    br = BR_NONE;
    case (op_q)
      OP_SET: begin
        if (wait_dir_q) br = BR_DIR;
        else if (wait_settle_q) br = BR_SETTLE;
        else if (mag_in_q == '0 || dir_q != fwd_q) br = BR_PAUSE;
        else br = BR_RUN;
      end
      OP_READ:  br = BR_READ;
      OP_CLEAR: br = BR_CLEAR;
      default:  br = BR_NONE;
    endcase
  end

  // Clip the magnitude to the bounds, upper bound last, then saturate.
  always_comb begin
    lo     = (cfg_i.period_min == '0) ? '0 : cfg_i.period_min - 25'd1;
    hi     = (cfg_i.period_max == '0) ? '0 : cfg_i.period_max - 25'd1;
    m_lo   = (mag_in_q < lo) ? lo : mag_in_q;
    m_hi   = (m_lo > hi) ? hi : m_lo;
    m_clip = (m_hi > MagLimit) ? MagLimit[23:0] : m_hi[23:0];
  end

  // One restoring divide step: the next dividend bit leaves the top of quo_q.
  always_comb begin
    trial = {rem_q, quo_q[15]} - {1'b0, 9'({1'b0, mag_q[23:16]} + 9'd1)};
    if (!trial[9]) begin
      rem_d = trial[8:0];
      quo_d = {quo_q[14:0], 1'b1};
    end else begin
      rem_d = 9'({rem_q[7:0], quo_q[15]});
      quo_d = {quo_q[14:0], 1'b0};
    end
  end

  // Position extension across a counter wrap.
  always_comb begin
    base_ext = base_q;
    if (cnt_q < last_q) begin
      base_ext = dir_q ? base_q + WrapAmt : base_q - WrapAmt;
    end
    pos_ext = dir_q ? base_ext + {16'd0, cnt_q} : base_ext - {16'd0, cnt_q};
  end

  assign status_o.need_div = (br == BR_RUN);
  assign status_o.div_last = (div_cnt_q == DivCntW'(DivSteps - 1));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Word capture and divider registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= op_e'(operation_i);
      mag_in_q <= period_i[24] ? 25'(-period_i) : period_i;
      fwd_q    <= !period_i[24];
      cnt_q    <= counter_value_i & CntMask;
    end
    if (cmd_i.prep) begin
      mag_q     <= m_clip;
      rem_q     <= {1'b0, m_clip[23:16]};
      quo_q     <= m_clip[15:0];
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q     <= rem_d;
      quo_q     <= quo_d;
      div_cnt_q <= div_cnt_q + DivCntW'(1);
    end
  end

  // Block state and result update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q        <= '0;
      last_q        <= '0;
      paused_q      <= 1'b1;
      wait_dir_q    <= 1'b1;
      wait_settle_q <= 1'b0;
      dir_q         <= 1'b0;
      presc_q       <= PausePrescaler;
      reload_q      <= PauseReload;
      compare_q     <= PauseCompare;
      out_valid_q   <= 1'b0;
      pos_out_q     <= '0;
      clr_out_q     <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
      clr_out_q   <= 1'b0;
      pos_out_q   <= base_q;
      case (br)
        BR_DIR: begin
          dir_q         <= fwd_q;
          wait_dir_q    <= 1'b0;
          wait_settle_q <= 1'b1;
        end
        BR_SETTLE: begin
          wait_settle_q <= 1'b0;
        end
        BR_PAUSE: begin
          if (!paused_q) begin
            compare_q <= PauseCompare;
            reload_q  <= PauseReload;
            presc_q   <= PausePrescaler;
            base_q    <= pos_ext;
            last_q    <= '0;
            clr_out_q <= 1'b1;
            pos_out_q <= pos_ext;
          end
          paused_q   <= 1'b1;
          wait_dir_q <= 1'b1;
        end
        BR_RUN: begin
          presc_q   <= mag_q[23:16];
          reload_q  <= quo_q;
          compare_q <= cfg_i.pulse_width;
          paused_q  <= 1'b0;
        end
        BR_READ: begin
          base_q    <= base_ext;
          last_q    <= cnt_q;
          pos_out_q <= pos_ext;
        end
        BR_CLEAR: begin
          last_q        <= '0;
          base_q        <= '0;
          wait_dir_q    <= 1'b0;
          wait_settle_q <= 1'b0;
          clr_out_q     <= 1'b1;
          pos_out_q     <= '0;
        end
        default: begin
          pos_out_q <= base_q;
        end
      endcase
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign direction_level_o = dir_q;
  assign prescaler_o       = presc_q;
  assign reload_o          = reload_q;
  assign compare_o         = compare_q;
  assign position_o        = pos_out_q;
  assign clear_counter_o   = clr_out_q;

  // A word is only committed into a free result slot.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || out_ready_i))
    else $error("commit while the result slot is occupied");

  // A result only appears after a commit.
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.commit))
    else $error("result valid without a commit");

  // A clear leaves the position at zero and the wait flags low.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && br == BR_CLEAR) |=>
      (base_q == '0 && !wait_dir_q && !wait_settle_q && clr_out_q))
    else $error("clear did not reset the position");

  // Divider steps never overlap a commit.
  a_div_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> !cmd_i.commit && !cmd_i.capture)
    else $error("divide step overlaps another command");

endmodule

// ----- rtl/step_pulse_rate_and_position_top.sv -----
// Sequence: a read, clear or non-running set word goes from IDLE through PREP to COMMIT,
// where its result is registered; a set word that loads a new period also passes DIV, the
// 16-step bit-serial reload divide, between PREP and COMMIT.
// Flow: one word at a time; the next word is accepted once the previous one is committed
// to the output register, even while that result waits.
// Reset: asynchronous, active low; position 0, pulses paused, timer 3/65535/0.
module step_pulse_rate_and_position_top import spr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [24:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic signed [24:0] period_i,
  input  logic [15:0]        counter_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               direction_level_o,
  output logic [7:0]         prescaler_o,
  output logic [15:0]        reload_o,
  output logic [15:0]        compare_o,
  output logic signed [31:0] position_o,
  output logic               clear_counter_o
);

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_min  <= 25'd100;
      cfg_q.period_max  <= 25'd16777216;
      cfg_q.pulse_width <= 16'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgPeriodMin:  cfg_q.period_min  <= cfg_data_i;
        CfgPeriodMax:  cfg_q.period_max  <= cfg_data_i;
        CfgPulseWidth: cfg_q.pulse_width <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  spr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  spr_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .cmd_i             (cmd),
    .status_o          (status),
    .operation_i       (operation_i),
    .period_i          (period_i),
    .counter_value_i   (counter_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .direction_level_o (direction_level_o),
    .prescaler_o       (prescaler_o),
    .reload_o          (reload_o),
    .compare_o         (compare_o),
    .position_o        (position_o),
    .clear_counter_o   (clear_counter_o)
  );

endmodule
